[src/omam_pkg.sv]
package omam_pkg;

  localparam int AXES = 6;
  localparam int DATA_W = 16;
  localparam int SUM_W = 24;
  localparam int MAG_W = 23;
  localparam int MUL_W = 24;
  localparam int PROD_W = MAG_W + MUL_W + 1;
  localparam int QUO_W = DATA_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int DEF_WINDOW_LENGTH = 200;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sample_t [AXES-1:0] axes_t;
  typedef sum_t [AXES-1:0] sums_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_X = 3'd0,
    CFG_ACCEL_Y = 3'd1,
    CFG_ACCEL_Z = 3'd2,
    CFG_GYRO_X  = 3'd3,
    CFG_GYRO_Y  = 3'd4,
    CFG_GYRO_Z  = 3'd5
  } cfg_idx_e;

  localparam sample_t OFFSET_RESET [AXES] = '{
    -16'sd195, 16'sd560, -16'sd169, 16'sd12, 16'sd33, 16'sd4
  };

  typedef struct packed {
    logic mag;
    logic mul;
    logic out;
  } div_en_t;

endpackage

[src/six_axis_offset_moving_average.sv]
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   six raw axes, 16 bit signed
// out      output     out_valid_o / out_stall_i six corrected, six averages
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one transfer per cycle sustained while out_stall_i is low; out_valid_o follows the input transfer
// latency is set by the window memory read, sum update, magnitude, multiply and
// output register stages; a stage holds only while the one after it is full and stalled
// reset loads the offsets and clears the sums; window entries read as zero until the
// write position first wraps, no clearing pass
// cfg_ready_o is always high
module six_axis_offset_moving_average #(
  parameter int WindowLength = omam_pkg::DEF_WINDOW_LENGTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [omam_pkg::DATA_W-1:0] accel_x_raw_i,
  input  logic signed [omam_pkg::DATA_W-1:0] accel_y_raw_i,
  input  logic signed [omam_pkg::DATA_W-1:0] accel_z_raw_i,
  input  logic signed [omam_pkg::DATA_W-1:0] gyro_x_raw_i,
  input  logic signed [omam_pkg::DATA_W-1:0] gyro_y_raw_i,
  input  logic signed [omam_pkg::DATA_W-1:0] gyro_z_raw_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [omam_pkg::DATA_W-1:0] accel_x_corrected_o,
  output logic signed [omam_pkg::DATA_W-1:0] accel_y_corrected_o,
  output logic signed [omam_pkg::DATA_W-1:0] accel_z_corrected_o,
  output logic signed [omam_pkg::DATA_W-1:0] gyro_x_corrected_o,
  output logic signed [omam_pkg::DATA_W-1:0] gyro_y_corrected_o,
  output logic signed [omam_pkg::DATA_W-1:0] gyro_z_corrected_o,
  output logic signed [omam_pkg::DATA_W-1:0] accel_x_average_o,
  output logic signed [omam_pkg::DATA_W-1:0] accel_y_average_o,
  output logic signed [omam_pkg::DATA_W-1:0] accel_z_average_o,
  output logic signed [omam_pkg::DATA_W-1:0] gyro_x_average_o,
  output logic signed [omam_pkg::DATA_W-1:0] gyro_y_average_o,
  output logic signed [omam_pkg::DATA_W-1:0] gyro_z_average_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [omam_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [omam_pkg::DATA_W-1:0]       cfg_data_i
);

  omam_pkg::sample_t offset_q [omam_pkg::AXES];
  omam_pkg::sum_t    sum_q    [omam_pkg::AXES];
  omam_pkg::sum_t    sum_d    [omam_pkg::AXES];
  omam_pkg::sums_t   sum2_q;

  omam_pkg::axes_t raw;
  omam_pkg::axes_t corr;
  omam_pkg::axes_t old;
  omam_pkg::axes_t avg;
  omam_pkg::axes_t corr1_q, corr2_q, corr3_q, corr4_q, corr5_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;
  logic en1, en2, en3, en4, en5;
  omam_pkg::div_en_t div_en;

  assign raw = {gyro_z_raw_i, gyro_y_raw_i, gyro_x_raw_i,
                accel_z_raw_i, accel_y_raw_i, accel_x_raw_i};

  always_comb begin
    for (int k = 0; k < omam_pkg::AXES; k++) begin
      corr[k]  = raw[k] - offset_q[k];
      sum_d[k] = sum_q[k]
               - omam_pkg::SUM_W'($signed(old[k]))
               + omam_pkg::SUM_W'($signed(corr1_q[k]));
    end
  end

  // stage holds while the next stage is full and not moving
  assign r5 = !v5_q || !out_stall_i;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;

  assign en1 = in_valid_i && r1;
  assign en2 = v1_q && r2;
  assign en3 = v2_q && r3;
  assign en4 = v3_q && r4;
  assign en5 = v4_q && r5;

  assign in_stall_o  = !r1;
  assign cfg_ready_o = 1'b1;

  assign div_en.mag = en3;
  assign div_en.mul = en4;
  assign div_en.out = en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      for (int k = 0; k < omam_pkg::AXES; k++) begin
        offset_q[k] <= omam_pkg::OFFSET_RESET[k];
        sum_q[k]    <= '0;
      end
    end else begin
      v1_q <= en1 || (v1_q && !en2);
      v2_q <= en2 || (v2_q && !en3);
      v3_q <= en3 || (v3_q && !en4);
      v4_q <= en4 || (v4_q && !en5);
      v5_q <= en5 || (v5_q && out_stall_i);
      if (en2) begin
        for (int k = 0; k < omam_pkg::AXES; k++) begin
          sum_q[k] <= sum_d[k];
        end
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          omam_pkg::CFG_ACCEL_X: offset_q[0] <= cfg_data_i;
          omam_pkg::CFG_ACCEL_Y: offset_q[1] <= cfg_data_i;
          omam_pkg::CFG_ACCEL_Z: offset_q[2] <= cfg_data_i;
          omam_pkg::CFG_GYRO_X:  offset_q[3] <= cfg_data_i;
          omam_pkg::CFG_GYRO_Y:  offset_q[4] <= cfg_data_i;
          omam_pkg::CFG_GYRO_Z:  offset_q[5] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) corr1_q <= corr;
    if (en2) begin
      corr2_q <= corr1_q;
      for (int k = 0; k < omam_pkg::AXES; k++) begin
        sum2_q[k] <= sum_d[k];
      end
    end
    if (en3) corr3_q <= corr2_q;
    if (en4) corr4_q <= corr3_q;
    if (en5) corr5_q <= corr4_q;
  end

  omam_window #(
    .WindowLength(WindowLength)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (en1),
    .wr_data_i (corr),
    .old_o     (old)
  );

  omam_mean_div #(
    .WindowLength(WindowLength)
  ) u_mean_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .sum_i (sum2_q),
    .avg_o (avg)
  );

  assign out_valid_o = v5_q;

  assign accel_x_corrected_o = corr5_q[0];
  assign accel_y_corrected_o = corr5_q[1];
  assign accel_z_corrected_o = corr5_q[2];
  assign gyro_x_corrected_o  = corr5_q[3];
  assign gyro_y_corrected_o  = corr5_q[4];
  assign gyro_z_corrected_o  = corr5_q[5];
  assign accel_x_average_o   = avg[0];
  assign accel_y_average_o   = avg[1];
  assign accel_z_average_o   = avg[2];
  assign gyro_x_average_o    = avg[3];
  assign gyro_y_average_o    = avg[4];
  assign gyro_z_average_o    = avg[5];

endmodule

[src/omam_window.sv]
module omam_window #(
  parameter int WindowLength = omam_pkg::DEF_WINDOW_LENGTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  omam_pkg::axes_t     wr_data_i,
  output omam_pkg::axes_t     old_o
);

  localparam int PosW = $clog2(WindowLength);

  omam_pkg::axes_t mem_q [WindowLength];
  omam_pkg::axes_t rd_q;
  logic            rd_valid_q;
  logic [PosW-1:0] pos_q;
  logic            wrapped_q;

  // entries not yet written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      wrapped_q  <= 1'b0;
      rd_valid_q <= 1'b0;
    end else if (wr_en_i) begin
      rd_valid_q <= wrapped_q;
      if (pos_q == PosW'(WindowLength - 1)) begin
        pos_q     <= '0;
        wrapped_q <= 1'b1;
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  // read old entry and overwrite it in the same cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rd_q          <= mem_q[pos_q];
      mem_q[pos_q]  <= wr_data_i;
    end
  end

  assign old_o = rd_valid_q ? rd_q : '0;

endmodule

[src/omam_mean_div.sv]
module omam_mean_div #(
  parameter int WindowLength = omam_pkg::DEF_WINDOW_LENGTH
) (
  input  logic              clk_i,
  input  omam_pkg::div_en_t en_i,
  input  omam_pkg::sums_t   sum_i,
  output omam_pkg::axes_t   avg_o
);

  localparam int Shift = omam_pkg::MAG_W + $clog2(WindowLength);
  localparam logic [63:0] Recip =
    ((64'd1 << Shift) + 64'(WindowLength) - 64'd1) / 64'(WindowLength);
  localparam logic [omam_pkg::MUL_W-1:0] RecipW = Recip[omam_pkg::MUL_W-1:0];

  logic [omam_pkg::MAG_W-1:0]  mag_q  [omam_pkg::AXES];
  logic [omam_pkg::AXES-1:0]   neg_q;
  logic [omam_pkg::PROD_W-1:0] prod_q [omam_pkg::AXES];
  logic [omam_pkg::AXES-1:0]   neg2_q;
  omam_pkg::axes_t             avg_q;

  logic [omam_pkg::MAG_W-1:0]  mag_d  [omam_pkg::AXES];
  logic [omam_pkg::SUM_W-1:0]  negsum [omam_pkg::AXES];
  logic [omam_pkg::QUO_W-1:0]  quo    [omam_pkg::AXES];
  logic [omam_pkg::QUO_W-1:0]  squo   [omam_pkg::AXES];

  always_comb begin
    for (int k = 0; k < omam_pkg::AXES; k++) begin
      negsum[k] = '0 - sum_i[k];
      mag_d[k]  = sum_i[k][omam_pkg::SUM_W-1] ? negsum[k][omam_pkg::MAG_W-1:0]
                                              : sum_i[k][omam_pkg::MAG_W-1:0];
      quo[k]    = prod_q[k][Shift +: omam_pkg::QUO_W];
      squo[k]   = neg2_q[k] ? ('0 - quo[k]) : quo[k];
    end
  end

  // magnitude, reciprocal multiply, then shift and sign restore
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < omam_pkg::AXES; k++) begin
      if (en_i.mag) begin
        mag_q[k] <= mag_d[k];
        neg_q[k] <= sum_i[k][omam_pkg::SUM_W-1];
      end
      if (en_i.mul) begin
        prod_q[k] <= omam_pkg::PROD_W'(mag_q[k]) * omam_pkg::PROD_W'(RecipW);
        neg2_q[k] <= neg_q[k];
      end
      if (en_i.out) begin
        avg_q[k] <= squo[k][omam_pkg::DATA_W-1:0];
      end
    end
  end

  assign avg_o = avg_q;

endmodule
